FILE: rtl/core/plid_pkg.sv
// Package for the positional list block: field widths, operation and status
// codes, and the control bundle that steers the row of storage cells.
// Depends on nothing; every other file in rtl/core imports it.
package plid_pkg;

  // Fixed field widths of the input and result beats.
  localparam int OP_W    = 2;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int EIDX_W  = 6;
  localparam int COUNT_W = 7;

  // Default number of list entries.
  localparam int DEPTH_DEF = 64;

  // Operation codes of the input beat.
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

  // Status codes of the result beat.
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  // Control bundle broadcast to all cells.
  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

FILE: rtl/core/plid_cell.sv
// One storage cell of the list: holds one entry and takes its next value
// from itself, its left or right neighbor, the head cell or the new value.
// Depends on plid_pkg.
module plid_cell #(
  parameter int DEPTH = plid_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                                clk,
  input  plid_pkg::cell_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0]            tail,
  input  logic signed [plid_pkg::VAL_W-1:0]   value,
  input  logic signed [plid_pkg::VAL_W-1:0]   left,
  input  logic signed [plid_pkg::VAL_W-1:0]   right,
  input  logic signed [plid_pkg::VAL_W-1:0]   head,
  output logic signed [plid_pkg::VAL_W-1:0]   entry
);
  import plid_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMP_W-1:0] IDX_C = CMP_W'(IDX);
  localparam logic [IDX_W-1:0] IDX_T = IDX_W'(IDX);

  logic [CMP_W-1:0]         pos_c;
  logic signed [VAL_W-1:0]  entry_next;

  assign pos_c = CMP_W'(ctl.pos);

  // Choose the source of this cell's next value by its place in the row.
  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CELL_INS: begin
        if (IDX_C > pos_c) begin
          entry_next = left;
        end else if (IDX_C == pos_c) begin
          entry_next = value;
        end
      end
      CELL_DEL: begin
        if (IDX_C >= pos_c) begin
          entry_next = right;
        end
      end
      CELL_ROT: begin
        if (IDX_T < tail) begin
          entry_next = right;
        end else if (IDX_T == tail) begin
          entry_next = head;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  // Entry storage; undefined until written, so no reset.
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

FILE: rtl/core/positional_list_insert_delete.sv
// Positional list: an ordered list of up to DEPTH signed 32-bit entries.
// Input channel (in_valid/in_stall) carries operation, position and value;
// output channel (out_valid/out_stall) carries status, element,
// element_index, count and last. A beat moves when valid is high and stall
// is low.
// Insert and delete shift the row and register the single status beat at the
// accepting edge, so it shows in the next cycle.
// A new input beat is taken each cycle while no display runs and the output
// register is empty or being drained, so the rate is one item per cycle.
// Display streams the entries one beat per cycle while the receiver does not
// stall, by rotating the used part of the row through the head cell. The
// accepting edge enters the display state, which then registers the beats;
// the input stays stalled until the last beat is registered, and after the
// last beat the row is back in order.
// Displaying an empty list gives one empty-status beat. Operation code three
// is taken and dropped.
// When the receiver stalls, the output beat holds and the block stops,
// stalling its input. Reset (rst, synchronous) empties the list and clears
// out_valid; entry storage itself is not cleared.
// Depends on plid_pkg and plid_cell.
module positional_list_insert_delete #(
  parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [plid_pkg::OP_W-1:0]             operation,
  input  logic [plid_pkg::POS_W-1:0]            position,
  input  logic signed [plid_pkg::VAL_W-1:0]     value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [plid_pkg::STAT_W-1:0]           status,
  output logic signed [plid_pkg::VAL_W-1:0]     element,
  output logic [plid_pkg::EIDX_W-1:0]           element_index,
  output logic [plid_pkg::COUNT_W-1:0]          count,
  output logic                                  last
);
  import plid_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        entry_count;
  logic [CNT_W-1:0]        entry_count_next;
  logic [IDX_W-1:0]        disp_idx;
  logic [IDX_W-1:0]        tail;
  logic                    disp_last;
  logic                    out_free;
  logic                    in_fire;
  logic                    is_full;
  logic                    is_empty;
  logic                    ins_ok;
  logic                    del_ok;
  logic                    rot;
  logic [CMP_W-1:0]        pos_c;
  logic [CMP_W-1:0]        cnt_c;
  logic [STAT_W-1:0]       op_status;
  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] cell_q [DEPTH];

  // Handshake and operation checks.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state == S_DISP) || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign pos_c    = CMP_W'(position);
  assign cnt_c    = CMP_W'(entry_count);
  assign is_full  = (entry_count == CNT_W'(DEPTH));
  assign is_empty = (entry_count == '0);
  assign ins_ok   = in_fire && (operation == OP_INSERT) && !is_full && (pos_c <= cnt_c);
  assign del_ok   = in_fire && (operation == OP_DELETE) && !is_empty && (pos_c < cnt_c);
  assign rot      = (state == S_DISP) && out_free;
  assign tail     = IDX_W'(entry_count - 1'b1);
  assign disp_last = (disp_idx == tail);

  // Status of a single-beat operation.
  always_comb begin
    op_status = ST_OK;
    case (operation)
      OP_INSERT: begin
        if (is_full) begin
          op_status = ST_FULL;
        end else if (pos_c > cnt_c) begin
          op_status = ST_BADPOS;
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          op_status = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          op_status = ST_BADPOS;
        end
      end
      OP_DISPLAY: begin
        op_status = ST_EMPTY;
      end
      default: begin
        op_status = ST_OK;
      end
    endcase
  end

  // Entry count after the current operation.
  always_comb begin
    entry_count_next = entry_count;
    if (ins_ok) begin
      entry_count_next = entry_count + 1'b1;
    end else if (del_ok) begin
      entry_count_next = entry_count - 1'b1;
    end
  end

  // Broadcast control to the row of cells.
  always_comb begin
    ctl.pos = position;
    if (ins_ok) begin
      ctl.op = CELL_INS;
    end else if (del_ok) begin
      ctl.op = CELL_DEL;
    end else if (rot) begin
      ctl.op = CELL_ROT;
    end else begin
      ctl.op = CELL_HOLD;
    end
  end

  // Row of cells: neighbors (value or self at the ends) and the head cell.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end

    plid_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .tail  (tail),
      .value (value),
      .left  (left_d),
      .right (right_d),
      .head  (cell_q[0]),
      .entry (cell_q[g])
    );
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      disp_idx    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            entry_count <= entry_count_next;
            if (operation == OP_DISPLAY && !is_empty) begin
              state    <= S_DISP;
              disp_idx <= '0;
            end else if (operation == OP_INSERT || operation == OP_DELETE ||
                         operation == OP_DISPLAY) begin
              out_valid     <= 1'b1;
              status        <= op_status;
              element       <= '0;
              element_index <= '0;
              count         <= COUNT_W'(entry_count_next);
              last          <= 1'b1;
            end
          end
        end
        S_DISP: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= ST_OK;
            element       <= cell_q[0];
            element_index <= EIDX_W'(disp_idx);
            count         <= COUNT_W'(entry_count);
            last          <= disp_last;
            disp_idx      <= IDX_W'(disp_idx + 1'b1);
            if (disp_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/plid_checker.sv
// Port-level checks for the positional list, with the bind that attaches
// them to positional_list_insert_delete. Depends on plid_pkg.
module plid_checker #(
  parameter int DEPTH = plid_pkg::DEPTH_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [plid_pkg::STAT_W-1:0]         status,
  input logic signed [plid_pkg::VAL_W-1:0]   element,
  input logic [plid_pkg::EIDX_W-1:0]         element_index,
  input logic [plid_pkg::COUNT_W-1:0]        count,
  input logic                                last
);
  import plid_pkg::*;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(element) &&
      $stable(element_index) && $stable(count) && $stable(last))
    else $error("stalled output beat changed");

  // Error and empty results are single beats with no entry data.
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last && element == '0 && element_index == '0)
    else $error("non-ok result carries entry data or is not last");

  // A display stream keeps going with the next index in the following cycle.
  a_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=>
      out_valid && element_index == EIDX_W'($past(element_index) + 1'b1))
    else $error("display stream broke or skipped an index");

  // No input is taken while a display stream is still running.
  a_no_in_mid_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input accepted during display stream");

  // The reported count never exceeds the list size.
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (DEPTH > 127) || (count <= COUNT_W'(DEPTH)))
    else $error("count exceeds list depth");

endmodule

bind positional_list_insert_delete plid_checker #(.DEPTH(DEPTH)) u_plid_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_insert_delete: drives insert, delete and
// display beats, keeps a shadow copy of the list and checks every result beat against it.
// Depends on plid_pkg and the RTL in rtl/core.
module tb_top;
  import plid_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 16;

  // One result beat as the block should present it.
  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] element;
    logic [EIDX_W-1:0]       element_index;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } list_beat_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          operation = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [VAL_W-1:0]  value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  element;
  logic [EIDX_W-1:0]        element_index;
  logic [COUNT_W-1:0]       count;
  logic                     last;

  // Shadow copy of the list and the beats still owed by the block.
  logic signed [VAL_W-1:0]  shadow_entries [LIST_DEPTH];
  int                       shadow_count = 0;
  list_beat_t               pending_beats [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  positional_list_insert_delete #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .position     (position),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .element      (element),
    .element_index(element_index),
    .count        (count),
    .last         (last)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Queue one expected beat; count is taken after the operation has been applied.
  function automatic void owe_beat(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] elem,
                                   int idx, logic is_last);
    list_beat_t b;
    b.status        = st;
    b.element       = elem;
    b.element_index = EIDX_W'(idx);
    b.count         = COUNT_W'(shadow_count);
    b.last          = is_last;
    pending_beats.push_back(b);
  endfunction

  // Apply one accepted input beat to the shadow list and queue the beats it causes.
  function automatic void apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                        logic signed [VAL_W-1:0] val);
    int i;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= LIST_DEPTH) begin
          owe_beat(ST_FULL, '0, 0, 1'b1);
        end else if (int'(pos) > shadow_count) begin
          owe_beat(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = shadow_count; i > int'(pos); i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[int'(pos)] = val;
          shadow_count++;
          owe_beat(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          owe_beat(ST_EMPTY, '0, 0, 1'b1);
        end else if (int'(pos) >= shadow_count) begin
          owe_beat(ST_BADPOS, '0, 0, 1'b1);
        end else begin
          for (i = int'(pos); i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i+1];
          end
          shadow_count--;
          owe_beat(ST_OK, '0, 0, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (shadow_count == 0) begin
          owe_beat(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            owe_beat(ST_OK, shadow_entries[i], i, i + 1 == shadow_count);
        end
      end
      default: begin
        // The unused code is swallowed without a result.
      end
    endcase
  endfunction

  // Send one input beat, with random idle cycles ahead of it, and wait until it is taken.
  // Valid stays high afterwards so back-to-back beats need no dip.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_list_op(op, pos, val);
  endtask

  // Hold the input idle until every owed beat has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  // Operations on an empty list and positions out of range.
  task automatic test_empty_list();
    send_item(OP_DISPLAY, 7'd0, 32'sd0);
    send_item(OP_DELETE, 7'd0, 32'sd1);
    send_item(OP_DELETE, 7'd127, -32'sd1);
    send_item(OP_INSERT, 7'd1, 32'sd5);
    send_item(OP_INSERT, 7'd127, 32'sh7FFF_FFFF);
    send_item(OP_UNUSED, 7'd127, -32'sd1);
    wait_for_results();
  endtask

  // Inserts at the front, middle and end with extreme values, a display, then deletes and a last display.
  task automatic test_edits();
    send_item(OP_INSERT, 7'd0, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 7'd0, 32'sh8000_0000);
    send_item(OP_INSERT, 7'd2, 32'sd0);
    send_item(OP_INSERT, 7'd1, -32'sd1);
    send_item(OP_INSERT, 7'd4, 32'sh5555_AAAA);
    send_item(OP_DISPLAY, 7'd0, 32'sd0);
    send_item(OP_DELETE, 7'd5, 32'sd0);
    send_item(OP_DELETE, 7'd4, 32'sd0);
    send_item(OP_DELETE, 7'd0, 32'sd0);
    send_item(OP_DELETE, 7'd1, 32'sd0);
    send_item(OP_UNUSED, 7'd0, 32'sd0);
    send_item(OP_DISPLAY, 7'd127, -32'sd1);
    wait_for_results();
  endtask

  // Random mix, mostly with legal positions; the insert share shrinks as the list fills.
  task automatic test_random_mix(input int n_items);
    int k;
    int sel;
    int insert_share;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    for (k = 0; k < n_items; k++) begin
      insert_share = (shadow_count < 16) ? 55 : (shadow_count < 48) ? 45 : 30;
      sel = $urandom_range(99);
      if (sel < 3) op = OP_UNUSED;
      else if (sel < 13) op = OP_DISPLAY;
      else if (sel < 13 + insert_share) op = OP_INSERT;
      else op = OP_DELETE;
      if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(127));
      else if (op == OP_INSERT) pos = POS_W'($urandom_range(shadow_count));
      else if (shadow_count > 0) pos = POS_W'($urandom_range(shadow_count - 1));
      else pos = '0;
      send_item(op, pos, $urandom);
    end
  endtask

  // Fill the list to the top, insert into the full list, show it all, then shrink it.
  task automatic test_full_list();
    while (shadow_count < LIST_DEPTH) begin
      send_item(OP_INSERT, POS_W'($urandom_range(shadow_count)), $urandom);
    end
    send_item(OP_INSERT, 7'd0, $urandom);
    send_item(OP_INSERT, 7'(LIST_DEPTH), $urandom);
    send_item(OP_INSERT, 7'd127, $urandom);
    send_item(OP_DISPLAY, 7'd0, 32'sd0);
    send_item(OP_DELETE, 7'(LIST_DEPTH), 32'sd0);
    send_item(OP_DELETE, 7'(LIST_DEPTH - 1), 32'sd0);
    send_item(OP_INSERT, 7'(LIST_DEPTH - 1), 32'sh8000_0000);
    send_item(OP_DELETE, 7'd0, 32'sd0);
  endtask

  // Compare one field; X or Z on the port counts as a mismatch.
  function automatic void check_field(string name, logic signed [63:0] exp_v,
                                      logic signed [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Check every result beat against the oldest owed beat.
  always @(posedge clk) begin
    list_beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d element %0d index %0d count %0d last %0d",
                 $time, status, element, element_index, count, last);
        error_count++;
      end else begin
        exp_beat = pending_beats.pop_front();
        check_field("status", 64'(exp_beat.status), 64'(status));
        check_field("element", 64'(exp_beat.element), 64'(element));
        check_field("element_index", 64'(exp_beat.element_index), 64'(element_index));
        check_field("count", 64'(exp_beat.count), 64'(count));
        check_field("last", 64'(exp_beat.last), 64'(last));
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sender mostly busy, receiver mostly stalled.
    send_idle_pct = 15;
    recv_idle_pct = 87;
    test_empty_list();
    test_edits();
    test_random_mix(10);
    wait_for_results();

    // Sender mostly idle, receiver mostly ready.
    send_idle_pct = 87;
    recv_idle_pct = 15;
    test_full_list();
    test_random_mix(5);
    wait_for_results();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(15);
    wait_for_results();

    // Let anything stray show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_beats.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
